// ===== rtl/lrb_pkg.sv =====
// shared types and constants for the line rasterizer bitmap block
package lrb_pkg;

   // fixed field widths
   localparam int COORD_W    = 4;
   localparam int ROW_BITS_W = 16;
   localparam int COUNT_W    = 4;
   localparam int OP_W       = 2;
   // doubled error term spans about -2*15 .. 2*15
   localparam int ERR_W      = COORD_W + 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // request beat
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COORD_W-1:0] row_select;
   } req_type;

   // response beat
   typedef struct packed {
      logic [ROW_BITS_W-1:0] row_bits;
      logic [COUNT_W-1:0]    pixels_drawn;
   } rsp_type;

   // one pixel from the line stepper
   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } pixel_type;

   // access to the framebuffer memory
   typedef struct packed {
      logic               clear;
      logic               plot;
      logic               read;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } fb_req_type;

   // control states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_READ
   } state_type;

endpackage

// ===== rtl/line_rasterizer_bitmap.sv =====
// line rasterizer top level: command control, stepper and framebuffer
// clear and unused op: result strobe in the cycle after accept, next beat taken at once
// read row: one registered memory read, merged with forwarding and row valid flags, then a registered result strobe
// draw: plots n pixels, n the major-axis length (0..15), one pixel per cycle
// through the framebuffer read-modify-write port; result strobe registered once no pixel is left
// reset: all rows read as zero at once through row valid flags, no clearing pass
module line_rasterizer_bitmap #(
   parameter int SCREEN = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lrb_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output lrb_pkg::rsp_type  rsp_data
);

   import lrb_pkg::*;

   state_type  state_ff, state_in;
   logic       rsp_strobe_ff, rsp_strobe_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       row_ok_ff, row_ok_in;

   logic              accept;
   logic              load;
   logic              run;
   fb_req_type        fb_req;
   pixel_type         pixel;
   logic [COUNT_W-1:0] count;
   logic [SCREEN-1:0] fb_row;

   assign busy       = state_ff != ST_IDLE;
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   lrb_step #(
      .SCREEN (SCREEN)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .run      (run),
      .req_data (req_data),
      .pixel    (pixel),
      .count    (count)
   );

   lrb_fbuf #(
      .SCREEN (SCREEN)
   ) u_fbuf (
      .clock  (clock),
      .reset  (reset),
      .fb_req (fb_req),
      .fb_row (fb_row)
   );

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      row_ok_in     = row_ok_ff;
      fb_req        = '0;
      load          = 1'b0;
      run           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  OP_CLEAR: begin
                     fb_req.clear  = 1'b1;
                     rsp_strobe_in = 1'b1;
                  end
                  OP_DRAW: begin
                     load     = 1'b1;
                     state_in = ST_DRAW;
                  end
                  OP_READ: begin
                     row_ok_in   = 32'(req_data.row_select) < SCREEN;
                     fb_req.read = row_ok_in;
                     fb_req.row  = req_data.row_select;
                     state_in    = ST_READ;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DRAW: begin
            run         = 1'b1;
            fb_req.plot = pixel.valid;
            fb_req.row  = pixel.row;
            fb_req.col  = pixel.col;
            if (!pixel.valid) begin
               rsp_strobe_in            = 1'b1;
               rsp_data_in.pixels_drawn = count;
               state_in                 = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_strobe_in        = 1'b1;
            rsp_data_in.row_bits = row_ok_ff ? ROW_BITS_W'(fb_row) : '0;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      row_ok_ff   <= row_ok_in;
   end

endmodule

// ===== rtl/lrb_fbuf.sv =====
// framebuffer memory with row valid flags and read-modify-write pixel plotting
module lrb_fbuf #(
   parameter int SCREEN = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrb_pkg::fb_req_type    fb_req,
   output logic [SCREEN-1:0]      fb_row
);

   localparam int ADDR_W = $clog2(SCREEN);
   localparam logic [SCREEN-1:0] COL0_BIT = {1'b1, {(SCREEN-1){1'b0}}};

   logic [SCREEN-1:0] mem [SCREEN];

   logic [SCREEN-1:0] row_valid_ff, row_valid_in;
   logic [SCREEN-1:0] rd_data_ff;
   logic              rd_valid_ff;
   logic              s2_plot_ff, s2_plot_in;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [SCREEN-1:0] s2_mask_ff;
   logic              last_wr_ff, last_wr_in;
   logic [ADDR_W-1:0] last_addr_ff;
   logic [SCREEN-1:0] last_data_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;
   logic [SCREEN-1:0] col_mask;
   logic              fwd;
   logic [SCREEN-1:0] base_row;
   logic [SCREEN-1:0] wr_data;

   // read side address and pixel mask, column 0 at the top bit
   assign rd_addr  = ADDR_W'(fb_req.row);
   assign rd_en    = fb_req.plot | fb_req.read;
   assign col_mask = COL0_BIT >> fb_req.col;

   // forward the row written last cycle, else memory data or zero if not written since reset or the last clear
   assign fwd      = last_wr_ff && (last_addr_ff == s2_addr_ff);
   assign base_row = fwd ? last_data_ff : (rd_valid_ff ? rd_data_ff : '0);
   assign wr_data  = base_row | s2_mask_ff;
   assign fb_row   = base_row;

   // row valid flags: a clear drops all rows at once
   always_comb begin
      row_valid_in = row_valid_ff;
      if (fb_req.clear) begin
         row_valid_in = '0;
      end else if (s2_plot_ff) begin
         row_valid_in[s2_addr_ff] = 1'b1;
      end
   end

   assign s2_plot_in = fb_req.plot;
   assign last_wr_in = s2_plot_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         s2_plot_ff   <= 1'b0;
         last_wr_ff   <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         s2_plot_ff   <= s2_plot_in;
         last_wr_ff   <= last_wr_in;
      end
   end

   // memory: one write port for the merged row, one registered read port
   always_ff @(posedge clock) begin
      if (s2_plot_ff) begin
         mem[s2_addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // second stage payload and write history for forwarding
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= row_valid_ff[rd_addr];
         s2_addr_ff  <= rd_addr;
         s2_mask_ff  <= fb_req.plot ? col_mask : '0;
      end
      last_addr_ff <= s2_addr_ff;
      last_data_ff <= wr_data;
   end

endmodule

// ===== rtl/lrb_step.sv =====
// line setup and bresenham stepper, one pixel per cycle along the major axis while run is high
module lrb_step #(
   parameter int SCREEN = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          run,
   input  lrb_pkg::req_type              req_data,
   output lrb_pkg::pixel_type            pixel,
   output logic [lrb_pkg::COUNT_W-1:0]   count
);

   import lrb_pkg::*;

   localparam int CMAX = SCREEN - 1;
   localparam int PAD_W = ERR_W - COORD_W - 1;

   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
      if (32'(v) > CMAX) begin
         return COORD_W'(CMAX);
      end
      return v;
   endfunction

   logic [COORD_W-1:0] x0, y0, x1, y1;
   logic [COORD_W-1:0] adx, ady;
   logic               steep;
   logic [COORD_W-1:0] p_maj, p_min, q_maj, q_min;
   logic               swap;
   logic [COORD_W-1:0] a_maj, a_min, b_maj, b_min;
   logic [COORD_W-1:0] dx, dy;

   logic [COORD_W-1:0]      k_ff, k_in;
   logic [COORD_W-1:0]      kend_ff, kend_in;
   logic [COORD_W-1:0]      m_ff, m_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [COORD_W-1:0]      dx_ff, dy_ff;
   logic                    down_ff, steep_ff;
   logic [COUNT_W-1:0]      count_ff;

   logic signed [ERR_W-1:0] err_dec;

   // clamp endpoints to the screen
   assign x0 = clamp_coord(req_data.start_x);
   assign y0 = clamp_coord(req_data.start_y);
   assign x1 = clamp_coord(req_data.end_x);
   assign y1 = clamp_coord(req_data.end_y);

   // steep test and axis swap
   assign adx   = (x0 > x1) ? (x0 - x1) : (x1 - x0);
   assign ady   = (y0 > y1) ? (y0 - y1) : (y1 - y0);
   assign steep = ady > adx;
   assign p_maj = steep ? y0 : x0;
   assign p_min = steep ? x0 : y0;
   assign q_maj = steep ? y1 : x1;
   assign q_min = steep ? x1 : y1;

   // order endpoints so the major coordinate grows
   assign swap  = p_maj > q_maj;
   assign a_maj = swap ? q_maj : p_maj;
   assign a_min = swap ? q_min : p_min;
   assign b_maj = swap ? p_maj : q_maj;
   assign b_min = swap ? p_min : q_min;
   assign dx    = b_maj - a_maj;
   assign dy    = (a_min > b_min) ? (a_min - b_min) : (b_min - a_min);

   // current pixel
   assign pixel.valid = k_ff != kend_ff;
   assign pixel.row   = steep_ff ? k_ff : m_ff;
   assign pixel.col   = steep_ff ? m_ff : k_ff;
   assign count       = count_ff;

   // error term update, kept doubled
   assign err_dec = err_ff - $signed({{PAD_W{1'b0}}, dy_ff, 1'b0});

   always_comb begin
      k_in    = k_ff;
      kend_in = kend_ff;
      m_in    = m_ff;
      err_in  = err_ff;
      if (load) begin
         k_in    = a_maj;
         kend_in = b_maj;
         m_in    = a_min;
         err_in  = $signed({{(ERR_W-COORD_W){1'b0}}, dx});
      end else if (run && pixel.valid) begin
         k_in   = k_ff + 1'b1;
         err_in = err_dec;
         if (err_dec < 0) begin
            m_in   = down_ff ? (m_ff - 1'b1) : (m_ff + 1'b1);
            err_in = err_dec + $signed({{PAD_W{1'b0}}, dx_ff, 1'b0});
         end
      end
   end

   // stepping position, reset leaves no pixel pending
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         kend_ff <= '0;
      end else begin
         k_ff    <= k_in;
         kend_ff <= kend_in;
      end
   end

   // line parameters and error term
   always_ff @(posedge clock) begin
      m_ff   <= m_in;
      err_ff <= err_in;
      if (load) begin
         dx_ff    <= dx;
         dy_ff    <= dy;
         down_ff  <= a_min > b_min;
         steep_ff <= steep;
         count_ff <= COUNT_W'(dx);
      end
   end

endmodule
